// ===== design/kvt_pkg.sv =====
// shared constants, codes and control types of the key/value table
package kvt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IN_W    = 72;
  localparam int OUT_W   = 40;

  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic exec;
  } kvt_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic scan_last;
    logic out_free;
  } kvt_stat_t;

endpackage

// ===== design/kvt_ctrl.sv =====
// controller state machine: accept, scan, final compare, execute
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  kvt_pkg::kvt_stat_t stat,
  output kvt_pkg::kvt_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = stat.in_clear ? S_EXEC : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/kvt_dp.sv =====
// datapath: key and value memories, valid bits, scan compare and result register
module kvt_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [kvt_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [kvt_pkg::OUT_W-1:0]  m_tdata,
  input  kvt_pkg::kvt_cmd_t          cmd,
  output kvt_pkg::kvt_stat_t         stat
);

  logic [kvt_pkg::KEY_W-1:0] key_mem [kvt_pkg::ENTRIES];
  logic [kvt_pkg::VAL_W-1:0] val_mem [kvt_pkg::ENTRIES];
  logic [kvt_pkg::ENTRIES-1:0] valid;
  logic [kvt_pkg::CNT_W-1:0]   count;

  logic [kvt_pkg::OP_W-1:0]  op;
  logic [kvt_pkg::KEY_W-1:0] key;
  logic [kvt_pkg::VAL_W-1:0] value;

  logic [kvt_pkg::IDX_W-1:0] scan_idx;
  logic [kvt_pkg::IDX_W-1:0] cmp_idx;
  logic                      cmp_en;
  logic [kvt_pkg::KEY_W-1:0] rd_key;
  logic [kvt_pkg::VAL_W-1:0] rd_val;

  logic                      hit;
  logic [kvt_pkg::IDX_W-1:0] hit_idx;
  logic [kvt_pkg::VAL_W-1:0] hit_val;
  logic                      free;
  logic [kvt_pkg::IDX_W-1:0] free_idx;

  logic                      cmp_hit;
  logic                      cmp_free;
  logic                      wr_key;
  logic                      wr_val;
  logic [kvt_pkg::IDX_W-1:0] wr_idx;

  logic [kvt_pkg::STAT_W-1:0]  res_status;
  logic [kvt_pkg::VAL_W-1:0]   res_found;
  logic [kvt_pkg::CNT_W-1:0]   count_next;
  logic [kvt_pkg::ENTRIES-1:0] valid_next;

  logic [kvt_pkg::STAT_W-1:0]  out_status;
  logic [kvt_pkg::VAL_W-1:0]   out_found;
  logic [kvt_pkg::COUNT_W-1:0] out_count;

  assign stat.in_clear  = (s_tdata[1:0] == kvt_pkg::OP_CLEAR);
  assign stat.scan_last = (scan_idx == kvt_pkg::IDX_W'(kvt_pkg::ENTRIES - 1));
  assign stat.out_free  = !m_tvalid || m_tready;

  assign cmp_hit  = cmp_en && valid[cmp_idx] && (rd_key == key) && !hit;
  assign cmp_free = cmp_en && !valid[cmp_idx] && !free;

  // input item latch and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= s_tdata[1:0];
      key   <= s_tdata[33:2];
      value <= s_tdata[65:34];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en   <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        cmp_en   <= 1'b0;
        hit      <= 1'b0;
        free     <= 1'b0;
      end else begin
        cmp_en <= cmd.step;
        if (cmd.step) begin
          scan_idx <= scan_idx + kvt_pkg::IDX_W'(1);
        end
        if (cmp_hit) begin
          hit <= 1'b1;
        end
        if (cmp_free) begin
          free <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      cmp_idx <= scan_idx;
    end
    if (cmp_hit) begin
      hit_idx <= cmp_idx;
      hit_val <= rd_val;
    end
    if (cmp_free) begin
      free_idx <= cmp_idx;
    end
  end

  // execute step
  always_comb begin
    res_status = kvt_pkg::ST_OK;
    res_found  = '0;
    count_next = count;
    valid_next = valid;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    wr_idx     = hit ? hit_idx : free_idx;
    case (op)
      kvt_pkg::OP_SET: begin
        if (hit) begin
          wr_val = 1'b1;
        end else if (free) begin
          wr_key             = 1'b1;
          wr_val             = 1'b1;
          valid_next[wr_idx] = 1'b1;
          count_next         = count + kvt_pkg::CNT_W'(1);
        end else begin
          res_status = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::OP_LOOKUP: begin
        if (hit) begin
          res_found = hit_val;
        end else begin
          res_status = kvt_pkg::ST_MISSING;
        end
      end
      kvt_pkg::OP_DELETE: begin
        if (hit) begin
          valid_next[hit_idx] = 1'b0;
          if (count != '0) begin
            count_next = count - kvt_pkg::CNT_W'(1);
          end
        end else begin
          res_status = kvt_pkg::ST_MISSING;
        end
      end
      kvt_pkg::OP_CLEAR: begin
        valid_next = '0;
        count_next = '0;
      end
      default: begin
        res_status = kvt_pkg::ST_OK;
      end
    endcase
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_key) begin
      key_mem[wr_idx] <= key;
    end
    if (cmd.exec && wr_val) begin
      val_mem[wr_idx] <= value;
    end
    if (cmd.step) begin
      rd_key <= key_mem[scan_idx];
      rd_val <= val_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_count  <= kvt_pkg::COUNT_W'(count_next);
    end
  end

  assign m_tdata = {1'b0, out_count, out_found, out_status};

endmodule

// ===== design/key_value_table.sv =====
// top level of the key/value table
// A set, lookup or delete passes through the accept state, a scan that reads
// the key memory once per entry via its single read port, a flush state for
// the last compare and the execute state, which waits while the output
// register holds an untaken result. A clear goes from the accept state
// straight to execute. The result appears in the cycle after execution and
// is held in an output register, so the block is ready for the next item
// while it waits to be taken. The store is empty after reset.
module key_value_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [kvt_pkg::IN_W-1:0]  s_tdata,  // op[1:0], key[33:2], value[65:34]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [kvt_pkg::OUT_W-1:0] m_tdata   // status[1:0], found_value[33:2], count[38:34]
);

  kvt_pkg::kvt_cmd_t  cmd;
  kvt_pkg::kvt_stat_t stat;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kvt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[38:34] <= kvt_pkg::ENTRIES))
    else $error("count beyond table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == kvt_pkg::ST_FULL)) |->
      (m_tdata[38:34] == kvt_pkg::COUNT_W'(kvt_pkg::ENTRIES)))
    else $error("full status with free entries");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != kvt_pkg::ST_OK)) |-> (m_tdata[33:2] == '0))
    else $error("found value on failed operation");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while busy");

endmodule
